// ===== rtl/acif_pkg.sv =====
// Package for the asymmetric compensation IIR filter core.
// Holds field widths, the operation codes, the controller states and the
// command and status structs between controller and datapath. No dependencies.
package acif_pkg;

    localparam int SMP_W  = 24;   // Q1.23 samples
    localparam int COEF_W = 32;   // Q8.24 coefficients
    localparam int PROD_W = SMP_W + COEF_W;
    localparam int FRAC_W = 24;   // coefficient fraction bits dropped on rounding
    localparam int CH_W   = 2;
    localparam int IDX_W  = 4;
    localparam int OP_W   = 2;
    localparam int STG_W  = 3;

    localparam logic [STG_W-1:0] STAGES_RST = 3'd4;

    typedef enum logic [OP_W-1:0] {
        OP_FILTER   = 2'd0,
        OP_LOAD_NUM = 2'd1,
        OP_LOAD_DEN = 2'd2
    } t_op;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_NUM,
        ST_DEN,
        ST_DRAIN1,
        ST_DRAIN2,
        ST_ROUND,
        ST_FINISH
    } t_state;

    typedef struct packed {
        logic clear_step;   // clear one history entry
        logic start;        // sample word accepted
        logic load_num;     // write numerator coefficient
        logic load_den;     // write denominator coefficient
        logic issue;        // issue one tap read
        logic round;        // round the accumulator
        logic finish;       // saturate and present the result
    } t_dp_cmd;

    typedef struct packed {
        logic clear_done;   // last history entry being cleared
        logic last_step;    // last tap of the current pass being issued
        logic out_free;     // output register can take a word
    } t_dp_stat;

endpackage

// ===== rtl/asym_compensation_iir_filter_core.sv =====
// Multi-channel direct form I IIR filter for asymmetric compensation.
// Input channel (i_in_valid / o_in_stall): a word is a coefficient load or a
// sample. Loads complete in the cycle they are taken and give no result;
// words with an unknown operation or a channel out of range are dropped.
// A sample of channel c runs the numerator pass over 2*MAX_STAGES+1 taps and
// the denominator pass over 2*MAX_STAGES taps through one shared multiplier,
// then rounds and saturates to Q1.23 into the result register. Samples go
// one at a time: a new word is taken only once the last sample has left
// its final step. The passes always walk the full history depth because
// the histories shift.
// Output channel (o_out_valid / i_out_stall): one word per sample. A stalled
// word holds; the next word is taken in meanwhile and waits in its final step.
// Reset (i_rst_n, synchronous): stage count returns to 4 and both histories
// are cleared in a pass over all entries, during which input words stall.
// Coefficients must be loaded before use. i_cfg_wr_en writes the stage
// count only while the block is idle; the user ensures this, not the block.
// Depends on acif_pkg, acif_ctrl, acif_dp, acif_ram.
module asym_compensation_iir_filter_core
    import acif_pkg::*;
#(
    parameter int CHANNELS   = 4,
    parameter int MAX_STAGES = 4
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_wr_en,
    input  logic [STG_W-1:0]         i_cfg_wr_data,
    input  logic                     i_in_valid,
    output logic                     o_in_stall,
    input  logic [OP_W-1:0]          i_operation,
    input  logic [CH_W-1:0]          i_channel,
    input  logic [IDX_W-1:0]         i_coef_index,
    input  logic signed [COEF_W-1:0] i_coef_value,
    input  logic signed [SMP_W-1:0]  i_sample_in,
    output logic                     o_out_valid,
    input  logic                     i_out_stall,
    output logic [CH_W-1:0]          o_out_channel,
    output logic signed [SMP_W-1:0]  o_sample_out,
    output logic                     o_saturated
);

    t_dp_cmd  cmd;
    t_dp_stat stat;

    acif_ctrl #(.CHANNELS(CHANNELS), .MAX_STAGES(MAX_STAGES)) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_operation  (i_operation),
        .i_channel    (i_channel),
        .i_coef_index (i_coef_index),
        .i_stat       (stat),
        .o_cmd        (cmd)
    );

    acif_dp #(.CHANNELS(CHANNELS), .MAX_STAGES(MAX_STAGES)) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_channel     (i_channel),
        .i_coef_index  (i_coef_index),
        .i_coef_value  (i_coef_value),
        .i_sample_in   (i_sample_in),
        .i_out_stall   (i_out_stall),
        .o_out_valid   (o_out_valid),
        .o_out_channel (o_out_channel),
        .o_sample_out  (o_sample_out),
        .o_saturated   (o_saturated)
    );

endmodule

// ===== rtl/acif_ram.sv =====
// Generic single write port, single read port RAM with registered read.
// No dependencies.
module acif_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 36
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/acif_ctrl.sv =====
// Controller of the IIR filter core: sequences history clearing, loads,
// the numerator and denominator passes, rounding and result hand-off.
// Depends on acif_pkg.
module acif_ctrl
    import acif_pkg::*;
#(
    parameter int CHANNELS   = 4,
    parameter int MAX_STAGES = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  logic [OP_W-1:0]  i_operation,
    input  logic [CH_W-1:0]  i_channel,
    input  logic [IDX_W-1:0] i_coef_index,
    input  t_dp_stat         i_stat,
    output t_dp_cmd          o_cmd
);

    localparam int TAPS = 2 * MAX_STAGES + 1;

    t_state r_state;
    t_state n_state;
    logic   ch_ok;
    logic   idx_ok;
    logic   take;

    assign ch_ok  = int'(i_channel) < CHANNELS;
    assign idx_ok = int'(i_coef_index) < TAPS;
    assign take   = (r_state == ST_IDLE) && i_in_valid && ch_ok;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR: begin
                if (i_stat.clear_done) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                if (take && i_operation == OP_FILTER) n_state = ST_NUM;
            end
            ST_NUM: begin
                if (i_stat.last_step) n_state = ST_DEN;
            end
            ST_DEN: begin
                if (i_stat.last_step) n_state = ST_DRAIN1;
            end
            ST_DRAIN1: n_state = ST_DRAIN2;
            ST_DRAIN2: n_state = ST_ROUND;
            ST_ROUND:  n_state = ST_FINISH;
            ST_FINISH: begin
                if (i_stat.out_free) n_state = ST_IDLE;
            end
            default: n_state = ST_CLEAR;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_stall = 1'b1;
        case (r_state)
            ST_CLEAR: begin
                o_cmd.clear_step = 1'b1;
            end
            ST_IDLE: begin
                o_in_stall     = 1'b0;
                o_cmd.start    = take && i_operation == OP_FILTER;
                o_cmd.load_num = take && idx_ok && i_operation == OP_LOAD_NUM;
                o_cmd.load_den = take && idx_ok && i_operation == OP_LOAD_DEN;
            end
            ST_NUM, ST_DEN: begin
                o_cmd.issue = 1'b1;
            end
            ST_ROUND: begin
                o_cmd.round = 1'b1;
            end
            ST_FINISH: begin
                o_cmd.finish = 1'b1;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

endmodule

// ===== rtl/acif_dp.sv =====
// Datapath of the IIR filter core: coefficient and history RAMs, tap counter,
// one shared multiplier, accumulator, rounding, saturation and output register.
// Depends on acif_pkg and acif_ram.
module acif_dp
    import acif_pkg::*;
#(
    parameter int CHANNELS   = 4,
    parameter int MAX_STAGES = 4
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_dp_cmd                  i_cmd,
    output t_dp_stat                 o_stat,
    input  logic                     i_cfg_wr_en,
    input  logic [STG_W-1:0]         i_cfg_wr_data,
    input  logic [CH_W-1:0]          i_channel,
    input  logic [IDX_W-1:0]         i_coef_index,
    input  logic signed [COEF_W-1:0] i_coef_value,
    input  logic signed [SMP_W-1:0]  i_sample_in,
    input  logic                     i_out_stall,
    output logic                     o_out_valid,
    output logic [CH_W-1:0]          o_out_channel,
    output logic signed [SMP_W-1:0]  o_sample_out,
    output logic                     o_saturated
);

    localparam int TAPS   = 2 * MAX_STAGES + 1;
    localparam int HIST   = 2 * MAX_STAGES;
    localparam int CDEPTH = CHANNELS * TAPS;
    localparam int HDEPTH = CHANNELS * HIST;
    localparam int CA_W   = $clog2(CDEPTH);
    localparam int HA_W   = $clog2(HDEPTH);
    localparam int KW     = $clog2(HIST + 1);
    localparam int ACC_W  = PROD_W + $clog2(2 * HIST + 1);
    localparam int RW     = ACC_W + 1 - FRAC_W;

    localparam logic signed [ACC_W:0] RND =
        {{(ACC_W + 1 - FRAC_W){1'b0}}, 1'b1, {(FRAC_W - 1){1'b0}}};
    localparam logic signed [RW-1:0] Q_MAX = {{(RW - SMP_W + 1){1'b0}}, {(SMP_W - 1){1'b1}}};
    localparam logic signed [RW-1:0] Q_MIN = ~Q_MAX;

    // Control registers
    logic [STG_W-1:0] r_stages;
    logic [HA_W-1:0]  r_clr_addr;
    logic [KW-1:0]    r_k;
    logic             r_pass;
    logic             r_s1_vld;
    logic             r_s1_pass;
    logic [KW-1:0]    r_s1_k;
    logic             r_s2_vld;
    logic             r_out_valid;

    // Payload registers
    logic [CH_W-1:0]          r_ch;
    logic signed [SMP_W-1:0]  r_x;
    logic                     r_s2_sub;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [ACC_W-1:0]  r_acc;
    logic signed [RW-1:0]     r_round;
    logic [CH_W-1:0]          r_out_ch;
    logic signed [SMP_W-1:0]  r_out_sample;
    logic                     r_out_sat;

    logic [KW-1:0]            order;
    logic                     last_step;
    logic                     out_free;
    int                       h_base;
    logic [CA_W-1:0]          c_raddr;
    logic [CA_W-1:0]          c_waddr;
    logic [HA_W-1:0]          h_raddr;
    logic [COEF_W-1:0]        num_rdata;
    logic [COEF_W-1:0]        den_rdata;
    logic [SMP_W-1:0]         ih_rdata;
    logic [SMP_W-1:0]         oh_rdata;
    logic                     ih_we;
    logic [HA_W-1:0]          ih_waddr;
    logic [SMP_W-1:0]         ih_wdata;
    logic                     oh_we;
    logic [HA_W-1:0]          oh_waddr;
    logic [SMP_W-1:0]         oh_wdata;
    logic                     s1_first;
    logic                     tap_en;
    logic                     shift_en;
    logic signed [COEF_W-1:0] coef_sel;
    logic signed [SMP_W-1:0]  mul_op;
    logic signed [PROD_W-1:0] prod;
    logic signed [ACC_W-1:0]  prod_ext;
    logic signed [ACC_W:0]    n_sum;
    logic signed [SMP_W-1:0]  n_q;
    logic                     n_sat;

    // Stage count clamped to 1..MAX_STAGES, order is twice that
    always_comb begin
        if (r_stages == '0) begin
            order = KW'(2);
        end else if (int'(r_stages) > MAX_STAGES) begin
            order = KW'(HIST);
        end else begin
            order = KW'(2 * int'(r_stages));
        end
    end

    // Taps run from HIST down; the denominator pass stops at 1 (a[0] is unused)
    assign last_step = r_pass ? (r_k == KW'(1)) : (r_k == '0);
    assign out_free  = !r_out_valid || !i_out_stall;

    assign o_stat.clear_done = (r_clr_addr == HA_W'(HDEPTH - 1));
    assign o_stat.last_step  = last_step;
    assign o_stat.out_free   = out_free;

    assign h_base  = int'(r_ch) * HIST;
    assign c_raddr = CA_W'(int'(r_ch) * TAPS + int'(r_k));
    assign c_waddr = CA_W'(int'(i_channel) * TAPS + int'(i_coef_index));
    assign h_raddr = (r_k == '0) ? HA_W'(h_base) : HA_W'(h_base + int'(r_k) - 1);

    // Read data of step k is h[k-1]; it moves to slot k, reads go downwards
    // so a slot is always read before it is overwritten.
    assign s1_first = r_s1_vld && !r_s1_pass && (r_s1_k == '0);
    assign shift_en = r_s1_vld && (r_s1_k != '0) && (int'(r_s1_k) < HIST);
    assign tap_en   = r_s1_vld && (r_s1_k <= order) && !(r_s1_pass && r_s1_k == '0);
    assign coef_sel = r_s1_pass ? den_rdata : num_rdata;
    assign mul_op   = s1_first ? r_x : (r_s1_pass ? oh_rdata : ih_rdata);
    assign prod     = coef_sel * mul_op;

    always_comb begin
        ih_we    = 1'b0;
        ih_waddr = HA_W'(h_base + int'(r_s1_k));
        ih_wdata = s1_first ? r_x : ih_rdata;
        if (i_cmd.clear_step) begin
            ih_we    = 1'b1;
            ih_waddr = r_clr_addr;
            ih_wdata = '0;
        end else if (!r_s1_pass && (shift_en || s1_first)) begin
            ih_we = 1'b1;
        end
    end

    always_comb begin
        oh_we    = 1'b0;
        oh_waddr = HA_W'(h_base + int'(r_s1_k));
        oh_wdata = oh_rdata;
        if (i_cmd.clear_step) begin
            oh_we    = 1'b1;
            oh_waddr = r_clr_addr;
            oh_wdata = '0;
        end else if (i_cmd.finish) begin
            oh_we    = out_free;
            oh_waddr = HA_W'(h_base);
            oh_wdata = n_q;
        end else if (r_s1_pass && shift_en) begin
            oh_we = 1'b1;
        end
    end

    assign prod_ext = {{(ACC_W - PROD_W){r_prod[PROD_W-1]}}, r_prod};
    assign n_sum    = {r_acc[ACC_W-1], r_acc} + RND;

    always_comb begin
        n_sat = 1'b1;
        if (r_round > Q_MAX) begin
            n_q = Q_MAX[SMP_W-1:0];
        end else if (r_round < Q_MIN) begin
            n_q = Q_MIN[SMP_W-1:0];
        end else begin
            n_q   = r_round[SMP_W-1:0];
            n_sat = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stages    <= STAGES_RST;
            r_clr_addr  <= '0;
            r_k         <= '0;
            r_pass      <= 1'b0;
            r_s1_vld    <= 1'b0;
            r_s1_pass   <= 1'b0;
            r_s1_k      <= '0;
            r_s2_vld    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_stages <= i_cfg_wr_data;
            end
            if (i_cmd.clear_step && !o_stat.clear_done) begin
                r_clr_addr <= r_clr_addr + HA_W'(1);
            end
            if (i_cmd.start) begin
                r_k    <= KW'(HIST);
                r_pass <= 1'b0;
            end else if (i_cmd.issue) begin
                if (last_step) begin
                    r_k    <= KW'(HIST);
                    r_pass <= 1'b1;
                end else begin
                    r_k <= r_k - KW'(1);
                end
            end
            r_s1_vld  <= i_cmd.issue;
            r_s1_pass <= r_pass;
            r_s1_k    <= r_k;
            r_s2_vld  <= r_s1_vld;
            if (i_cmd.finish && out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_ch <= i_channel;
            r_x  <= i_sample_in;
        end
        r_s2_sub <= r_s1_pass;
        r_prod   <= tap_en ? prod : '0;
        if (i_cmd.start) begin
            r_acc <= '0;
        end else if (r_s2_vld) begin
            r_acc <= r_s2_sub ? r_acc - prod_ext : r_acc + prod_ext;
        end
        if (i_cmd.round) begin
            r_round <= n_sum[ACC_W:FRAC_W];
        end
        if (i_cmd.finish && out_free) begin
            r_out_ch     <= r_ch;
            r_out_sample <= n_q;
            r_out_sat    <= n_sat;
        end
    end

    acif_ram #(.WIDTH(COEF_W), .DEPTH(CDEPTH)) u_num_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.load_num),
        .i_waddr (c_waddr),
        .i_wdata (i_coef_value),
        .i_raddr (c_raddr),
        .o_rdata (num_rdata)
    );

    acif_ram #(.WIDTH(COEF_W), .DEPTH(CDEPTH)) u_den_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.load_den),
        .i_waddr (c_waddr),
        .i_wdata (i_coef_value),
        .i_raddr (c_raddr),
        .o_rdata (den_rdata)
    );

    acif_ram #(.WIDTH(SMP_W), .DEPTH(HDEPTH)) u_ih_ram (
        .i_clk   (i_clk),
        .i_we    (ih_we),
        .i_waddr (ih_waddr),
        .i_wdata (ih_wdata),
        .i_raddr (h_raddr),
        .o_rdata (ih_rdata)
    );

    acif_ram #(.WIDTH(SMP_W), .DEPTH(HDEPTH)) u_oh_ram (
        .i_clk   (i_clk),
        .i_we    (oh_we),
        .i_waddr (oh_waddr),
        .i_wdata (oh_wdata),
        .i_raddr (h_raddr),
        .o_rdata (oh_rdata)
    );

    assign o_out_valid   = r_out_valid;
    assign o_out_channel = r_out_ch;
    assign o_sample_out  = r_out_sample;
    assign o_saturated   = r_out_sat;

endmodule
